>>> hdl/thermal_false_color_map_macros.svh
// Assertion macros for the false color map
`ifndef THERMAL_FALSE_COLOR_MAP_MACROS_SVH
`define THERMAL_FALSE_COLOR_MAP_MACROS_SVH

`ifndef SYNTH
`define TFCM_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tfcm assertion failed");
`define TFCM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tfcm assertion failed");
`else
`define TFCM_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define TFCM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/tfcm_pkg.sv
package tfcm_pkg;

    localparam int TEMP_W     = 14;
    localparam int DIFF_W     = TEMP_W + 1;
    localparam int DEN_W      = TEMP_W;
    localparam int QUO_W      = 16;
    localparam int FRAC_W     = QUO_W + 1;
    localparam int PAL_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 16;
    localparam int HOT_A_W    = 15;

    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SELECT = 2'd2;

    localparam logic [TEMP_W-1:0] RANGE_LOW_RST  = 14'd320;
    localparam logic [TEMP_W-1:0] RANGE_HIGH_RST = 14'd640;

    localparam logic [PAL_W-1:0] PAL_IRON    = 3'd0;
    localparam logic [PAL_W-1:0] PAL_RAINBOW = 3'd1;
    localparam logic [PAL_W-1:0] PAL_GRAY    = 3'd2;
    localparam logic [PAL_W-1:0] PAL_HOT     = 3'd3;
    localparam logic [PAL_W-1:0] PAL_JET     = 3'd4;

    typedef enum logic [1:0] {
        HOT_NONE  = 2'b00,
        HOT_GREEN = 2'b01,
        HOT_BLUE  = 2'b10
    } hot_sel_t;

    typedef struct packed {
        logic              valid;
        logic              zero;
        logic              sat;
        logic [DEN_W-1:0]  rem;
        logic [DEN_W-1:0]  den;
        logic [QUO_W-1:0]  quo;
    } div_word_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } rgb_t;

    // floor(d * k / 65536), saturated at 255
    function automatic logic [CHAN_W-1:0] ramp_up(input logic [FRAC_W-1:0] d,
                                                  input logic [10:0] k);
        logic [27:0] prod;
        prod = 28'(d) * 28'(k);
        ramp_up = (prod[27:16] > 12'd255) ? 8'd255 : prod[23:16];
    endfunction

    // 255 - ceil(d * k / 65536), floored at 0
    function automatic logic [CHAN_W-1:0] ramp_down(input logic [FRAC_W-1:0] d,
                                                    input logic [10:0] k);
        logic [28:0] prod;
        prod = 29'(d) * 29'(k) + 29'd65535;
        ramp_down = (prod[28:16] > 13'd255) ? 8'd0 : 8'(8'd255 - prod[23:16]);
    endfunction

endpackage

>>> hdl/tfcm_div_cell.sv
module tfcm_div_cell
    import tfcm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_word_t word_in,
    output div_word_t word_out
);

    div_word_t           word_reg;
    div_word_t           word_next;
    logic [DEN_W:0]      rem_dbl;
    logic                take;

    always_comb begin
        rem_dbl   = {word_in.rem, 1'b0};
        take      = rem_dbl >= {1'b0, word_in.den};
        word_next = word_in;
        word_next.rem = take ? DEN_W'(rem_dbl - {1'b0, word_in.den}) : DEN_W'(rem_dbl);
        word_next.quo = {word_in.quo[QUO_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
        end else begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

>>> hdl/tfcm_palette.sv
module tfcm_palette
    import tfcm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  logic [FRAC_W-1:0] in_frac,
    input  logic [PAL_W-1:0]  palette_select,
    output logic              out_valid,
    output rgb_t              out_color
);

    logic                 p1_valid_reg;
    rgb_t                 p1_color_reg;
    rgb_t                 p1_color_next;
    logic [HOT_A_W-1:0]   p1_hot_a_reg;
    logic [HOT_A_W-1:0]   p1_hot_a_next;
    hot_sel_t             p1_hot_sel_reg;
    hot_sel_t             p1_hot_sel_next;
    logic                 p2_valid_reg;
    rgb_t                 p2_color_reg;
    rgb_t                 p2_color_next;

    logic [18:0]          hue;
    logic [15:0]          hue_frac;
    logic [CHAN_W-1:0]    hue_up;
    logic [CHAN_W-1:0]    hue_dn;
    logic [33:0]          hot_prod;
    logic [17:0]          hot_scaled;
    logic [27:0]          hot_quo_prod;
    logic [CHAN_W-1:0]    hot_chan;

    always_comb begin
        hue        = {in_frac, 2'b00} + 19'(in_frac);
        hue_frac   = hue[15:0];
        hue_up     = ramp_up({1'b0, hue_frac}, 11'd255);
        hue_dn     = ramp_up(FRAC_ONE - {1'b0, hue_frac}, 11'd255);
        hot_prod   = 34'(in_frac) * 34'd76500;
        hot_scaled = hot_prod[33:16];

        p1_color_next   = '0;
        p1_hot_a_next   = '0;
        p1_hot_sel_next = HOT_NONE;

        case (palette_select)
            PAL_IRON: begin
                if (in_frac < 17'd16384) begin
                    p1_color_next.blue = ramp_up(in_frac, 11'd1020);
                end else if (in_frac < 17'd32768) begin
                    p1_color_next.green = ramp_up(in_frac - 17'd16384, 11'd1020);
                    p1_color_next.blue  = 8'd255;
                end else if (in_frac < 17'd49152) begin
                    p1_color_next.red   = ramp_up(in_frac - 17'd32768, 11'd1020);
                    p1_color_next.green = 8'd255;
                    p1_color_next.blue  = ramp_down(in_frac - 17'd32768, 11'd1020);
                end else begin
                    p1_color_next.red   = 8'd255;
                    p1_color_next.green = 8'd255;
                    p1_color_next.blue  = ramp_down(in_frac - 17'd49152, 11'd1020);
                end
            end
            PAL_RAINBOW: begin
                case (hue[18:16])
                    3'd0: begin
                        p1_color_next.red   = 8'd255;
                        p1_color_next.green = hue_up;
                    end
                    3'd1: begin
                        p1_color_next.red   = hue_dn;
                        p1_color_next.green = 8'd255;
                    end
                    3'd2: begin
                        p1_color_next.green = 8'd255;
                        p1_color_next.blue  = hue_up;
                    end
                    3'd3: begin
                        p1_color_next.green = hue_dn;
                        p1_color_next.blue  = 8'd255;
                    end
                    3'd4: begin
                        p1_color_next.red  = hue_up;
                        p1_color_next.blue = 8'd255;
                    end
                    default: begin
                        p1_color_next.red  = 8'd255;
                        p1_color_next.blue = hue_dn;
                    end
                endcase
            end
            PAL_GRAY: begin
                p1_color_next.red   = ramp_up(in_frac, 11'd255);
                p1_color_next.green = p1_color_next.red;
                p1_color_next.blue  = p1_color_next.red;
            end
            PAL_HOT: begin
                if (in_frac < 17'd21627) begin
                    p1_color_next.red = ramp_up(in_frac, 11'd765);
                end else if (in_frac < 17'd43254) begin
                    p1_color_next.red = 8'd255;
                    p1_hot_a_next     = HOT_A_W'(hot_scaled - 18'd25245);
                    p1_hot_sel_next   = HOT_GREEN;
                end else begin
                    p1_color_next.red   = 8'd255;
                    p1_color_next.green = 8'd255;
                    p1_hot_a_next       = HOT_A_W'(hot_scaled - 18'd50490);
                    p1_hot_sel_next     = HOT_BLUE;
                end
            end
            PAL_JET: begin
                if (in_frac < 17'd8192) begin
                    p1_color_next.blue = 8'(8'd128 + ramp_up(in_frac, 11'd1016));
                end else if (in_frac < 17'd24576) begin
                    p1_color_next.green = ramp_up(in_frac - 17'd8192, 11'd1020);
                    p1_color_next.blue  = 8'd255;
                end else if (in_frac < 17'd40960) begin
                    p1_color_next.red   = ramp_up(in_frac - 17'd24576, 11'd1020);
                    p1_color_next.green = 8'd255;
                    p1_color_next.blue  = ramp_down(in_frac - 17'd24576, 11'd1020);
                end else if (in_frac < 17'd57344) begin
                    p1_color_next.red   = 8'd255;
                    p1_color_next.green = ramp_down(in_frac - 17'd40960, 11'd1020);
                end else begin
                    p1_color_next.red = ramp_down(in_frac - 17'd57344, 11'd1016);
                end
            end
            default: begin
                p1_color_next = '0;
            end
        endcase
    end

    // divide by 100 through a reciprocal, exact over the hot range
    always_comb begin
        hot_quo_prod  = 28'(p1_hot_a_reg) * 28'd5243;
        hot_chan      = (hot_quo_prod[27:19] > 9'd255) ? 8'd255 : hot_quo_prod[26:19];
        p2_color_next = p1_color_reg;
        case (p1_hot_sel_reg)
            HOT_GREEN: p2_color_next.green = hot_chan;
            HOT_BLUE:  p2_color_next.blue  = hot_chan;
            default:   p2_color_next       = p1_color_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_color_reg   <= p1_color_next;
        p1_hot_a_reg   <= p1_hot_a_next;
        p1_hot_sel_reg <= p1_hot_sel_next;
        p2_color_reg   <= p2_color_next;
    end

    assign out_valid = p2_valid_reg;
    assign out_color = p2_color_reg;

endmodule

>>> hdl/tfcm_out_fifo.sv
module tfcm_out_fifo
    import tfcm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_en,
    input  rgb_t wr_data,
    input  logic rd_en,
    output logic rd_valid,
    output rgb_t rd_data
);

    rgb_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  out_valid_reg;
    rgb_t                  out_data_reg;
    logic                  pop;
    logic                  load;
    logic                  from_mem;
    logic                  bypass;
    logic                  push;

    assign rd_valid = out_valid_reg;
    assign rd_data  = out_data_reg;
    assign pop      = rd_en && out_valid_reg;
    assign load     = !out_valid_reg || pop;
    assign from_mem = load && (count_reg != '0);
    assign bypass   = load && (count_reg == '0) && wr_en;
    assign push     = wr_en && !bypass;

    always_comb begin
        count_next = count_reg;
        case ({push, from_mem})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (from_mem) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (load) begin
                out_valid_reg <= from_mem || wr_en;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
        if (from_mem) begin
            out_data_reg <= mem_reg[rd_ptr_reg];
        end else if (bypass) begin
            out_data_reg <= wr_data;
        end
    end

endmodule

>>> hdl/thermal_false_color_map.sv
// Thermal false color map.
// s_ channel: one signed temperature word (sixteenths of a degree) per handshake.
// m_ channel: one color word per input word: 8-bit red, green, blue and RGB565.
// cfg port: range_low (index 0), range_high (index 1), palette_select (index 2),
// written with cfg_wr_en; change them only while no word is in flight.
// Throughput: one word per cycle, sustained while m_ready is held high.
// Path from input handshake to m_valid: one setup stage, a chain of 16 divider
// cells (one quotient bit each), two palette stages and a 32-entry output queue.
// s_ready is low only when 32 words are accepted and not yet taken; each word
// is given a queue slot on entry, so a stalled receiver never loses data and
// the input keeps flowing until the queue budget is used up.
// Reset (aresetn low, synchronous) empties the pipeline and queue and loads
// range_low 320, range_high 640 and the iron palette.
module thermal_false_color_map
    import tfcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [TEMP_W-1:0]    s_temperature,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [CHAN_W-1:0]    m_red,
    output logic [CHAN_W-1:0]    m_green,
    output logic [CHAN_W-1:0]    m_blue,
    output logic [PIX_W-1:0]     m_pixel_565
);

`include "thermal_false_color_map_macros.svh"

    logic [TEMP_W-1:0]     range_low_reg;
    logic [TEMP_W-1:0]     range_high_reg;
    logic [PAL_W-1:0]      palette_select_reg;

    logic [FIFO_CNT_W-1:0] inflight_reg;
    logic [FIFO_CNT_W-1:0] inflight_next;
    logic                  s_accept;
    logic                  m_accept;

    logic signed [DIFF_W-1:0] diff_num;
    logic signed [DIFF_W-1:0] diff_den;
    logic signed [DIFF_W-1:0] mag_num;
    logic signed [DIFF_W-1:0] mag_den;
    div_word_t                prep_next;
    div_word_t                chain [QUO_W+1];

    logic [FRAC_W-1:0]     frac;
    logic                  pal_valid;
    rgb_t                  pal_color;
    rgb_t                  out_color;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_low_reg      <= RANGE_LOW_RST;
            range_high_reg     <= RANGE_HIGH_RST;
            palette_select_reg <= PAL_IRON;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_RANGE_LOW:      range_low_reg      <= cfg_data;
                CFG_RANGE_HIGH:     range_high_reg     <= cfg_data;
                CFG_PALETTE_SELECT: palette_select_reg <= cfg_data[PAL_W-1:0];
                default:            range_low_reg      <= range_low_reg;
            endcase
        end
    end

    assign s_ready  = inflight_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign s_accept = s_valid && s_ready;
    assign m_accept = m_valid && m_ready;

    always_comb begin
        inflight_next = inflight_reg;
        case ({s_accept, m_accept})
            2'b10:   inflight_next = inflight_reg + 1'b1;
            2'b01:   inflight_next = inflight_reg - 1'b1;
            default: inflight_next = inflight_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_next;
        end
    end

    always_comb begin
        diff_num = $signed({s_temperature[TEMP_W-1], s_temperature})
                 - $signed({range_low_reg[TEMP_W-1], range_low_reg});
        diff_den = $signed({range_high_reg[TEMP_W-1], range_high_reg})
                 - $signed({range_low_reg[TEMP_W-1], range_low_reg});
        mag_num  = diff_den[DIFF_W-1] ? -diff_num : diff_num;
        mag_den  = diff_den[DIFF_W-1] ? -diff_den : diff_den;

        prep_next       = '0;
        prep_next.valid = s_accept;
        prep_next.zero  = mag_num[DIFF_W-1] || (mag_num == '0);
        prep_next.sat   = !prep_next.zero
                       && (mag_num[DEN_W-1:0] >= mag_den[DEN_W-1:0]);
        prep_next.rem   = mag_num[DEN_W-1:0];
        prep_next.den   = mag_den[DEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain[0] <= '0;
        end else begin
            chain[0] <= prep_next;
        end
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_cell
        tfcm_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .word_in  (chain[i]),
            .word_out (chain[i+1])
        );
    end

    always_comb begin
        if (chain[QUO_W].zero) begin
            frac = '0;
        end else if (chain[QUO_W].sat) begin
            frac = FRAC_ONE;
        end else begin
            frac = {1'b0, chain[QUO_W].quo};
        end
    end

    tfcm_palette u_palette (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (chain[QUO_W].valid),
        .in_frac        (frac),
        .palette_select (palette_select_reg),
        .out_valid      (pal_valid),
        .out_color      (pal_color)
    );

    tfcm_out_fifo u_out_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (pal_valid),
        .wr_data  (pal_color),
        .rd_en    (m_ready),
        .rd_valid (m_valid),
        .rd_data  (out_color)
    );

    assign m_red       = out_color.red;
    assign m_green     = out_color.green;
    assign m_blue      = out_color.blue;
    assign m_pixel_565 = {out_color.red[7:3], out_color.green[7:2], out_color.blue[7:3]};

    `TFCM_ASSERT_IMPLY(a_inflight_bound, aclk, aresetn, 1'b1,
        inflight_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `TFCM_ASSERT_IMPLY(a_out_has_credit, aclk, aresetn, m_valid, inflight_reg != '0)
    `TFCM_ASSERT_IMPLY(a_pipe_has_credit, aclk, aresetn, pal_valid, inflight_reg != '0)
    `TFCM_ASSERT_NEXT(a_accept_enters_chain, aclk, aresetn, s_accept, chain[0].valid)

endmodule

>>> sim/thermal_false_color_map_checker.sv
`timescale 1ns / 1ps

module thermal_false_color_map_checker
    import tfcm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEMP_W-1:0]    cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [TEMP_W-1:0]    s_temperature,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [CHAN_W-1:0]    m_red,
    input  logic [CHAN_W-1:0]    m_green,
    input  logic [CHAN_W-1:0]    m_blue,
    input  logic [PIX_W-1:0]     m_pixel_565,
    output int                   fail_count,
    output int                   pending
);

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [PIX_W-1:0]  pixel;
    } color_word_t;

    logic [TEMP_W-1:0] low_limit;
    logic [TEMP_W-1:0] high_limit;
    logic [PAL_W-1:0]  palette;
    color_word_t       pending_colors[$];
    color_word_t       want;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [FRAC_W-1:0] unit_fraction(input int t, input int lo, input int hi);
        longint num;
        longint den;
        longint q;
        den = hi - lo;
        if (den == 0)
            return (t > lo) ? FRAC_W'(65536) : FRAC_W'(0);
        num = longint'(t - lo) * 65536;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return FRAC_W'(0);
        q = num / den;
        return (q > 65536) ? FRAC_W'(65536) : FRAC_W'(q);
    endfunction

    function automatic logic [CHAN_W-1:0] rise(input longint d, input longint k);
        longint v;
        v = (d * k) >>> 16;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic logic [CHAN_W-1:0] fall(input longint d, input longint k);
        longint c;
        c = (d * k + 65535) >>> 16;
        return (c > 255) ? 8'd0 : 8'(255 - c);
    endfunction

    function automatic logic [CHAN_W-1:0] hot_level(input longint fx, input longint base);
        longint v;
        v = ((fx * 100 - base) * 765) / 6553600;
        return (v > 255) ? 8'd255 : 8'(v);
    endfunction

    function automatic color_word_t predict_color(input logic [FRAC_W-1:0] f,
                                                  input logic [PAL_W-1:0] pal);
        longint            fx;
        longint            h;
        longint            fr;
        int                sector;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
        logic [CHAN_W-1:0] up;
        logic [CHAN_W-1:0] dn;
        color_word_t       c;
        fx = f;
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        case (pal)
            PAL_IRON: begin
                if (fx < 16384) begin
                    b = rise(fx, 1020);
                end else if (fx < 32768) begin
                    g = rise(fx - 16384, 1020);
                    b = 8'd255;
                end else if (fx < 49152) begin
                    r = rise(fx - 32768, 1020);
                    g = 8'd255;
                    b = fall(fx - 32768, 1020);
                end else begin
                    r = 8'd255;
                    g = 8'd255;
                    b = fall(fx - 49152, 1020);
                end
            end
            PAL_RAINBOW: begin
                h = fx * 5;
                sector = int'((h >>> 16) % 6);
                fr = h & 65535;
                up = rise(fr, 255);
                dn = rise(65536 - fr, 255);
                case (sector)
                    0: begin
                        r = 8'd255;
                        g = up;
                    end
                    1: begin
                        r = dn;
                        g = 8'd255;
                    end
                    2: begin
                        g = 8'd255;
                        b = up;
                    end
                    3: begin
                        g = dn;
                        b = 8'd255;
                    end
                    4: begin
                        r = up;
                        b = 8'd255;
                    end
                    default: begin
                        r = 8'd255;
                        b = dn;
                    end
                endcase
            end
            PAL_GRAY: begin
                r = rise(fx, 255);
                g = r;
                b = r;
            end
            PAL_HOT: begin
                if (fx * 100 < longint'(33) * 65536) begin
                    r = rise(fx, 765);
                end else if (fx * 100 < longint'(66) * 65536) begin
                    r = 8'd255;
                    g = hot_level(fx, longint'(33) * 65536);
                end else begin
                    r = 8'd255;
                    g = 8'd255;
                    b = hot_level(fx, longint'(66) * 65536);
                end
            end
            PAL_JET: begin
                if (fx < 8192) begin
                    b = 8'd128 + rise(fx, 1016);
                end else if (fx < 24576) begin
                    g = rise(fx - 8192, 1020);
                    b = 8'd255;
                end else if (fx < 40960) begin
                    r = rise(fx - 24576, 1020);
                    g = 8'd255;
                    b = fall(fx - 24576, 1020);
                end else if (fx < 57344) begin
                    r = 8'd255;
                    g = fall(fx - 40960, 1020);
                end else begin
                    r = fall(fx - 57344, 1016);
                end
            end
            default: begin
            end
        endcase
        c.red = r;
        c.green = g;
        c.blue = b;
        c.pixel = {r[7:3], g[7:2], b[7:3]};
        return c;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            low_limit <= RANGE_LOW_RST;
            high_limit <= RANGE_HIGH_RST;
            palette <= PAL_IRON;
            pending_colors.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RANGE_LOW:      low_limit <= cfg_data;
                    CFG_RANGE_HIGH:     high_limit <= cfg_data;
                    CFG_PALETTE_SELECT: palette <= cfg_data[PAL_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                pending_colors.push_back(predict_color(
                    unit_fraction(int'($signed(s_temperature)), int'($signed(low_limit)),
                                  int'($signed(high_limit))),
                    palette));
            end
            if (m_valid && m_ready) begin
                if (pending_colors.size() == 0) begin
                    $error("color word with no sample outstanding: r %0d g %0d b %0d",
                           m_red, m_green, m_blue);
                    fail_count++;
                end else begin
                    want = pending_colors.pop_front();
                    if (m_red !== want.red) begin
                        $error("red mismatch: expected %0d, got %0d", want.red, m_red);
                        fail_count++;
                    end
                    if (m_green !== want.green) begin
                        $error("green mismatch: expected %0d, got %0d", want.green, m_green);
                        fail_count++;
                    end
                    if (m_blue !== want.blue) begin
                        $error("blue mismatch: expected %0d, got %0d", want.blue, m_blue);
                        fail_count++;
                    end
                    if (m_pixel_565 !== want.pixel) begin
                        $error("pixel_565 mismatch: expected %0h, got %0h",
                               want.pixel, m_pixel_565);
                        fail_count++;
                    end
                end
            end
        end
        pending = pending_colors.size();
    end

endmodule

>>> sim/tb_thermal_false_color_map.sv
`timescale 1ns / 1ps

module tb_thermal_false_color_map;
    import tfcm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 1650;
    localparam int HOLD_CYCLES   = 300;
    localparam int TEMP_MIN      = -8192;
    localparam int TEMP_MAX      = 8191;
    localparam logic [PAL_W-1:0] PAL_UNUSED_LO = 3'd5;
    localparam logic [PAL_W-1:0] PAL_UNUSED_HI = 3'd7;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TEMP_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [TEMP_W-1:0]    s_temperature;
    logic                 m_valid;
    logic                 m_ready;
    logic [CHAN_W-1:0]    m_red;
    logic [CHAN_W-1:0]    m_green;
    logic [CHAN_W-1:0]    m_blue;
    logic [PIX_W-1:0]     m_pixel_565;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    bit                   no_gaps;
    bit                   hold_req;
    int                   hold_count;
    int                   rx_left;

    thermal_false_color_map dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temperature (s_temperature),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_pixel_565   (m_pixel_565)
    );

    thermal_false_color_map_checker u_color_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temperature (s_temperature),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_pixel_565   (m_pixel_565),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_RANGE_LOW;
        cfg_data = '0;
        s_valid = 1'b0;
        s_temperature = '0;
        m_ready = 1'b0;
        no_gaps = 1'b0;
        hold_req = 1'b0;
        hold_count = 0;
        rx_left = 0;
        cycle_count = 0;
    end

    always #10 aclk = ~aclk;

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(negedge aclk) begin
        if (hold_req) begin
            m_ready <= 1'b0;
            hold_count++;
            if (hold_count >= HOLD_CYCLES) begin
                hold_req = 1'b0;
                hold_count = 0;
                rx_left = 0;
            end
        end else if (rx_left > 0) begin
            rx_left--;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready <= 1'b0;
            rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
            rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 90) : $urandom_range(0, 6);
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int clamp_temp(input int t);
        if (t < TEMP_MIN)
            return TEMP_MIN;
        if (t > TEMP_MAX)
            return TEMP_MAX;
        return t;
    endfunction

    function automatic int pick_temp(input int lo, input int hi);
        int a;
        int b;
        int span;
        int r;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        span = b - a;
        r = $urandom_range(0, 9);
        if (r < 2)
            return int'($signed(TEMP_W'($urandom)));
        if (r == 2) begin
            case ($urandom_range(0, 7))
                0: return lo;
                1: return hi;
                2: return clamp_temp(lo - 1);
                3: return clamp_temp(lo + 1);
                4: return clamp_temp(hi - 1);
                5: return clamp_temp(hi + 1);
                6: return TEMP_MIN;
                default: return TEMP_MAX;
            endcase
        end
        return clamp_temp(a - span / 8 - 2 + int'($urandom_range(0, span + span / 4 + 4)));
    endfunction

    task automatic send_temp(input int t);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_temperature <= TEMP_W'(t);
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    task automatic drain_and_program(input int lo, input int hi, input logic [PAL_W-1:0] pal);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_RANGE_LOW;
        cfg_data <= TEMP_W'(lo);
        @(negedge aclk);
        cfg_index <= CFG_RANGE_HIGH;
        cfg_data <= TEMP_W'(hi);
        @(negedge aclk);
        cfg_index <= CFG_PALETTE_SELECT;
        if ($urandom_range(0, 1) == 0)
            cfg_data <= {(TEMP_W - PAL_W)'($urandom), pal};
        else
            cfg_data <= {{(TEMP_W - PAL_W){1'b0}}, pal};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int               lo;
        int               hi;
        int               span;
        int               count;
        int               sent;
        int               phase_no;
        int               p;
        logic [PAL_W-1:0] pal;

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: iron over 320..640
        send_temp(TEMP_MIN);
        send_temp(TEMP_MAX);
        send_temp(320);
        send_temp(640);
        send_temp(480);

        drain_and_program(TEMP_MIN, TEMP_MAX, PAL_RAINBOW);
        send_temp(TEMP_MIN);
        send_temp(TEMP_MAX);
        send_temp(0);

        drain_and_program(TEMP_MIN, TEMP_MAX, PAL_GRAY);
        send_temp(-1);
        send_temp(4000);

        // hot: breakpoints at 33 and 66, blue saturates near the top
        drain_and_program(0, 100, PAL_HOT);
        send_temp(32);
        send_temp(33);
        send_temp(66);
        send_temp(99);
        send_temp(100);

        drain_and_program(0, 1000, PAL_JET);
        send_temp(0);
        send_temp(124);
        send_temp(500);
        send_temp(875);
        send_temp(1000);

        // empty range
        drain_and_program(100, 100, PAL_IRON);
        send_temp(100);
        send_temp(101);

        // inverted range
        drain_and_program(640, 320, PAL_GRAY);
        send_temp(700);
        send_temp(480);

        drain_and_program(0, 100, PAL_UNUSED_HI);
        send_temp(50);

        sent = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            lo = int'($urandom_range(0, 16383)) + TEMP_MIN;
            case ($urandom_range(0, 9))
                0: begin
                    lo = TEMP_MIN;
                    hi = TEMP_MAX;
                end
                1: begin
                    lo = TEMP_MAX;
                    hi = TEMP_MIN;
                end
                2: hi = lo;
                3: hi = clamp_temp(lo - int'($urandom_range(1, 600)));
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        span = $urandom_range(400, 16383);
                    else
                        span = $urandom_range(1, 400);
                    hi = clamp_temp(lo + span);
                end
            endcase
            p = $urandom_range(0, 11);
            if (p < 10)
                pal = PAL_W'(p % 5);
            else
                pal = PAL_W'($urandom_range(PAL_UNUSED_LO, PAL_UNUSED_HI));
            drain_and_program(lo, hi, pal);

            if (phase_no == 2 || phase_no == 20) begin
                count = 80;
                no_gaps = 1'b1;
                @(posedge aclk);
                hold_req = 1'b1;
            end else begin
                count = $urandom_range(10, 60);
                no_gaps = ($urandom_range(0, 3) == 0);
            end
            for (int i = 0; i < count; i++) begin
                send_temp(pick_temp(lo, hi));
                sent++;
            end
            phase_no++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
